// File: sv/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared types and constants for the bencode value scanner.
// ----------------------------------------------------------------------------
package bvs_pkg;

   localparam int unsigned MaxNestingDefault = 16;
   localparam int unsigned PosW = 31;
   localparam int unsigned LenW = 32;
   localparam int unsigned IntW = 64;
   localparam int unsigned CsrAddrW = 3;
   localparam int unsigned CsrDataW = 32;
   localparam int unsigned ReqDataW = 8;
   // value_start, value_end, inner_start, inner_end, integer_value, padded to bytes
   localparam int unsigned RspFieldsW = 4 * PosW + IntW;
   localparam int unsigned RspDataW = ((RspFieldsW + 7) / 8) * 8;
   localparam int unsigned RspUserW = 3;

   localparam logic [LenW-1:0] LENGTH_LIMIT = 32'h1000_0000;

   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_L     = 8'h6C;
   localparam logic [7:0] CHAR_D     = 8'h64;
   localparam logic [7:0] CHAR_E     = 8'h65;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [1:0] KIND_INT  = 2'd0;
   localparam logic [1:0] KIND_STR  = 2'd1;
   localparam logic [1:0] KIND_LIST = 2'd2;
   localparam logic [1:0] KIND_DICT = 2'd3;

   localparam logic [CsrAddrW-1:0] CSR_BASE_POSITION = 3'd0;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      logic            status;
      logic [1:0]      value_kind;
      logic [PosW-1:0] value_start;
      logic [PosW-1:0] value_end;
      logic [PosW-1:0] inner_start;
      logic [PosW-1:0] inner_end;
      logic [IntW-1:0] integer_value;
   } result_type;

endpackage

// File: sv/bvs_csr.sv
// ----------------------------------------------------------------------------
// bvs_csr
// APB register slave holding the base position register.
// ----------------------------------------------------------------------------
module bvs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bvs_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [bvs_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [bvs_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                          csr_pready,
   output logic [bvs_pkg::PosW-1:0]      base_position
);
   import bvs_pkg::*;

   logic [PosW-1:0] base_ff, base_in;
   logic            sel_base;

   // register index is the word address; low byte bits are ignored
   assign sel_base = (csr_paddr[CsrAddrW-1:2] == CSR_BASE_POSITION[CsrAddrW-1:2]);

   always_comb begin
      base_in = base_ff;
      if (csr_psel && csr_penable && csr_pwrite && sel_base) begin
         base_in = csr_pwdata[PosW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   assign csr_pready    = 1'b1;
   assign csr_prdata    = sel_base ? {{(CsrDataW-PosW){1'b0}}, base_ff} : '0;
   assign base_position = base_ff;

endmodule

// File: sv/bvs_in_stage.sv
// ----------------------------------------------------------------------------
// bvs_in_stage
// Input register: captures one byte item and holds it until the scan core
// consumes it.
// ----------------------------------------------------------------------------
module bvs_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bvs_pkg::ReqDataW-1:0]  req_tdata,   // [7:0] byte_in
   input  logic                          req_tlast,   // last_byte
   output logic                          item_valid,
   output bvs_pkg::item_type             item,
   input  logic                          item_take
);
   import bvs_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_tready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff && !item_take;
      item_in  = item_ff;
      if (req_tvalid && req_tready) begin
         valid_in          = 1'b1;
         item_in.byte_in   = req_tdata[7:0];
         item_in.last_byte = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: sv/bvs_scan_core.sv
// ----------------------------------------------------------------------------
// bvs_scan_core
// Per-byte scan step: mode, nesting depth, length and integer accumulators,
// plus the result register.
// ----------------------------------------------------------------------------
module bvs_scan_core #(
   parameter int unsigned MAX_NESTING = bvs_pkg::MaxNestingDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [bvs_pkg::PosW-1:0]  base_position,
   input  logic                      item_valid,
   input  bvs_pkg::item_type         item,
   output logic                      item_take,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bvs_pkg::result_type       rsp
);
   import bvs_pkg::*;

   // depth may reach MAX_NESTING + 1; any further byte other than e is then rejected
   localparam int unsigned DepthW = $clog2(MAX_NESTING + 2);
   localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_NESTING);

   localparam logic [2:0] MODE_EXPECT     = 3'd0;
   localparam logic [2:0] MODE_INT_SIGN   = 3'd1;
   localparam logic [2:0] MODE_INT_FIRST  = 3'd2;
   localparam logic [2:0] MODE_INT_DIGITS = 3'd3;
   localparam logic [2:0] MODE_STR_LEN    = 3'd4;
   localparam logic [2:0] MODE_STR_BODY   = 3'd5;
   localparam logic [2:0] MODE_DONE       = 3'd6;

   logic [2:0]        mode_ff, mode_in;
   logic [DepthW-1:0] depth_ff, depth_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [LenW-1:0]   len_ff, len_in;
   logic [LenW-1:0]   body_ff, body_in;
   logic [IntW-1:0]   iacc_ff, iacc_in;
   logic              neg_ff, neg_in;
   logic [1:0]        kind_ff, kind_in;
   logic [PosW-1:0]   inner_ff, inner_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   logic [7:0]      c;
   logic            is_digit;
   logic [3:0]      digit;
   logic [PosW-1:0] next_pos;
   logic            fire;
   logic            done_hit, err, res;
   logic [PosW-1:0] done_end, done_iend;
   logic [IntW-1:0] signed_val;

   assign c        = item.byte_in;
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign digit    = c[3:0];
   assign next_pos = pos_ff + PosW'(1);
   assign fire     = item_valid && (!rsp_valid_ff || rsp_ready);
   assign item_take = fire;

   always_comb begin
      mode_in   = mode_ff;
      depth_in  = depth_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      body_in   = body_ff;
      iacc_in   = iacc_ff;
      neg_in    = neg_ff;
      kind_in   = kind_ff;
      inner_in  = inner_ff;
      done_hit  = 1'b0;
      done_end  = next_pos;
      done_iend = next_pos;
      err       = 1'b0;
      res       = 1'b0;
      signed_val = '0;
      rsp_in    = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (fire) begin
         unique case (mode_ff)
            MODE_EXPECT: begin
               if (c == CHAR_E && depth_ff != '0) begin
                  depth_in  = depth_ff - DepthW'(1);
                  done_hit  = 1'b1;
                  done_iend = pos_ff;
               end else if (depth_ff > DepthMax) begin
                  err = 1'b1;
               end else if (c == CHAR_I) begin
                  if (depth_ff == '0) begin
                     kind_in  = KIND_INT;
                     inner_in = next_pos;
                     iacc_in  = '0;
                     neg_in   = 1'b0;
                  end
                  mode_in = MODE_INT_SIGN;
               end else if (c == CHAR_L || c == CHAR_D) begin
                  if (depth_ff == '0) begin
                     kind_in  = (c == CHAR_L) ? KIND_LIST : KIND_DICT;
                     inner_in = next_pos;
                  end
                  depth_in = depth_ff + DepthW'(1);
               end else if (is_digit) begin
                  if (depth_ff == '0) begin
                     kind_in = KIND_STR;
                  end
                  len_in  = LenW'(digit);
                  mode_in = MODE_STR_LEN;
               end else begin
                  err = 1'b1;
               end
            end
            MODE_INT_SIGN, MODE_INT_FIRST: begin
               if (mode_ff == MODE_INT_SIGN && c == CHAR_MINUS) begin
                  if (depth_ff == '0) begin
                     neg_in = 1'b1;
                  end
                  mode_in = MODE_INT_FIRST;
               end else if (is_digit) begin
                  if (depth_ff == '0) begin
                     iacc_in = (iacc_ff << 3) + (iacc_ff << 1) + IntW'(digit);
                  end
                  mode_in = MODE_INT_DIGITS;
               end else begin
                  err = 1'b1;
               end
            end
            MODE_INT_DIGITS: begin
               if (is_digit) begin
                  if (depth_ff == '0) begin
                     iacc_in = (iacc_ff << 3) + (iacc_ff << 1) + IntW'(digit);
                  end
               end else if (c == CHAR_E) begin
                  done_hit  = 1'b1;
                  done_iend = pos_ff;
               end else begin
                  err = 1'b1;
               end
            end
            MODE_STR_LEN: begin
               if (is_digit) begin
                  if (len_ff > LENGTH_LIMIT) begin
                     err = 1'b1;
                  end else begin
                     len_in = (len_ff << 3) + (len_ff << 1) + LenW'(digit);
                  end
               end else if (c == CHAR_COLON) begin
                  if (depth_ff == '0) begin
                     inner_in = next_pos;
                  end
                  if (len_ff == '0) begin
                     done_hit = 1'b1;
                  end else begin
                     body_in = len_ff;
                     mode_in = MODE_STR_BODY;
                  end
               end else begin
                  err = 1'b1;
               end
            end
            MODE_STR_BODY: begin
               body_in = body_ff - LenW'(1);
               if (body_in == '0) begin
                  done_hit = 1'b1;
               end
            end
            default: begin
            end
         endcase

         // a value closed: only the outermost one produces a result
         signed_val = neg_in ? (IntW'(0) - iacc_in) : iacc_in;
         if (done_hit) begin
            if (depth_in != '0) begin
               mode_in = MODE_EXPECT;
            end else begin
               res                  = 1'b1;
               rsp_in.status        = 1'b0;
               rsp_in.value_kind    = kind_in;
               rsp_in.value_start   = base_position;
               rsp_in.value_end     = base_position + done_end;
               rsp_in.inner_start   = base_position + inner_in;
               rsp_in.inner_end     = base_position + done_iend;
               rsp_in.integer_value = (kind_in == KIND_INT) ? signed_val : '0;
            end
         end

         // malformed, or document ended before the top value closed
         if (err || (item.last_byte && !res && mode_ff != MODE_DONE)) begin
            res    = 1'b1;
            rsp_in = '{status: 1'b1, default: '0};
         end

         if (res) begin
            mode_in      = MODE_DONE;
            rsp_valid_in = 1'b1;
         end

         if (item.last_byte) begin
            mode_in  = MODE_EXPECT;
            depth_in = '0;
            pos_in   = '0;
            len_in   = '0;
            body_in  = '0;
            iacc_in  = '0;
            neg_in   = 1'b0;
            kind_in  = KIND_INT;
            inner_in = '0;
         end else begin
            pos_in = next_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_EXPECT;
         depth_ff     <= '0;
         pos_ff       <= '0;
         len_ff       <= '0;
         body_ff      <= '0;
         iacc_ff      <= '0;
         neg_ff       <= 1'b0;
         kind_ff      <= KIND_INT;
         inner_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         depth_ff     <= depth_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         body_ff      <= body_in;
         iacc_ff      <= iacc_in;
         neg_ff       <= neg_in;
         kind_ff      <= kind_in;
         inner_ff     <= inner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef ASSERT_OFF
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DepthMax + DepthW'(1))
      else $error("nesting depth past its bound");

   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      fire && item.last_byte |=> pos_ff == '0 && depth_ff == '0 && mode_ff == MODE_EXPECT)
      else $error("document state not cleared after final byte");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status |-> rsp_ff.value_kind == '0
         && rsp_ff.value_end == '0 && rsp_ff.integer_value == '0)
      else $error("error item carries nonzero fields");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_STR_BODY |-> body_ff != '0)
      else $error("string body count empty while skipping body");
`endif

endmodule

// File: sv/bencode_value_scanner.sv
// ----------------------------------------------------------------------------
// bencode_value_scanner
// Checks that a byte stream opens with one well-formed bencode value and
// reports its kind, positions and integer value.
// ----------------------------------------------------------------------------
// One byte is taken per clock and the scanner sustains one byte every cycle
// while the result side is ready; each byte passes an input register, a
// combinational scan step (mode, depth and the shift-add accumulators), and
// the result register, so a result is presented in the cycle after the scan
// step takes its closing byte. At most one result item is produced per
// document; the byte flagged with tlast always ends the document and returns
// the scanner to its reset state, keeping base_position. Write base_position
// only while no document is in flight.
module bencode_value_scanner #(
   parameter int unsigned MAX_NESTING = bvs_pkg::MaxNestingDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   // byte items
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [bvs_pkg::ReqDataW-1:0]  req_tdata,   // [7:0] byte_in
   input  logic                          req_tlast,   // last_byte
   // result items
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [30:0] value_start, [61:31] value_end, [92:62] inner_start,
   // [123:93] inner_end, [187:124] integer_value, [191:188] zero
   output logic [bvs_pkg::RspDataW-1:0]  rsp_tdata,
   output logic [bvs_pkg::RspUserW-1:0]  rsp_tuser,   // [0] status, [2:1] value_kind
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bvs_pkg::CsrAddrW-1:0]  csr_paddr,
   input  logic [bvs_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [bvs_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                          csr_pready
);
   import bvs_pkg::*;

   logic [PosW-1:0] base_position;
   logic            item_valid;
   logic            item_take;
   item_type        item;
   result_type      rsp;

   bvs_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .base_position (base_position)
   );

   bvs_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   bvs_scan_core #(
      .MAX_NESTING (MAX_NESTING)
   ) u_scan_core (
      .clock         (clock),
      .reset         (reset),
      .base_position (base_position),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp           (rsp)
   );

   assign rsp_tdata = {{(RspDataW-RspFieldsW){1'b0}}, rsp.integer_value, rsp.inner_end,
                       rsp.inner_start, rsp.value_end, rsp.value_start};
   assign rsp_tuser = {rsp.value_kind, rsp.status};

endmodule
